### rtl/core/tcs_pkg.sv
// Package for the tridiagonal coefficient stencil.
// Holds sizes, the cell job type and fixed-point helpers; no dependencies.
package tcs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // register indexes of the config port
  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_WIDTH     = 3'd1;
  localparam logic [2:0] REG_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_DISP_GAIN = 3'd3;
  localparam logic [2:0] REG_ADV_GAIN  = 3'd4;

  localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
  localparam logic [31:0] INT_MAX  = 32'h7FFF_FFFF;
  localparam logic [62:0] PROD_LIM = 63'h4000_0000_0000_0000;

  // one pending result: stencil cells plus its place in the grid
  typedef struct packed {
    logic [31:0]      here;
    logic [31:0]      prev;
    logic [31:0]      next;
    logic             skip;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } job_t;

  // cells next to the border along the stencil axis
  function automatic logic edge_pos(input logic [10:0] pos, input logic [10:0] size);
    logic [11:0] sum;
    sum = {1'b0, pos} + 12'd3;
    return (pos <= 11'd2) || (sum >= {1'b0, size});
  endfunction

  // combine split gain product, truncate, clamp magnitude at 2^62
  function automatic logic [62:0] gain_sat(input logic [48:0] p1, input logic [63:0] p0);
    logic [62:0] sum;
    sum = {1'b0, p1[45:0], 16'b0} + {15'b0, p0[63:16]};
    if (p1 >= 49'h4000_0000_0000) return PROD_LIM;
    if (sum > PROD_LIM) return PROD_LIM;
    return sum;
  endfunction

  // saturate to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    if (v > $signed({33'b0, INT_MAX})) return INT_MAX;
    if (v < -$signed({33'b0, INT_MAX}) - 65'sd1) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

### rtl/core/tridiag_coef_stencil.sv
// Top level of the tridiagonal coefficient stencil.
// Uses tcs_pkg; holds the two row stores, the window and the coefficient datapath.
//
// Usage: grid cells stream in raster order on in_* (one transfer per cell).
// in_tdata carries the bed elevation, in_tuser the dry flag. Results leave on
// out_*: three Q16.16 coefficients plus the cell's row and column in
// out_tdata, out_tlast marks the final result of the grid. Along x a result
// leaves when the right neighbor arrives; along y when the cell below arrives,
// so the last two rows come out interleaved (up to two results per cell).
// The cfg_* port writes direction, width, height and the two gains; write
// only while the block is idle.
// Sequence: a cell first fetches its row-store entries (read at accept, then
// write-back in the fetch state), then each result passes through the
// operand, square and gain multiply stages and the final sum, where it waits
// while the receiver stalls. A new cell is accepted only after the previous
// cell's last result has issued; the multiply chain, run once per result, dominates.
// Reset clears counters, window and config to their defaults; row stores are
// not cleared; an entry is used only after being written. When out_tready is
// low the result waits in the output register; processing halts at ST_FIN.
module tridiag_coef_stencil (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] bottom_elevation
  input  logic         in_tuser,   // [0] dry_flag
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // [31:0] coef_lower, [63:32] coef_diag,
                                   // [95:64] coef_upper, [105:96] row_index,
                                   // [115:106] col_index, [119:116] zero
  output logic         out_tlast,  // frame_last
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import tcs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_OPS   = 3'd2;
  localparam logic [2:0] ST_MUL1  = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // config registers
  logic        dir_r;
  logic [10:0] gw_r, gh_r;
  logic [31:0] gain_s_r, gain_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      gw_r     <= 11'd1024;
      gh_r     <= 11'd1024;
      gain_s_r <= 32'd26214;
      gain_a_r <= 32'd5461;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIRECTION: dir_r    <= cfg_wdata[0];
        REG_WIDTH:     gw_r     <= cfg_wdata[10:0];
        REG_HEIGHT:    gh_r     <= cfg_wdata[10:0];
        REG_DISP_GAIN: gain_s_r <= cfg_wdata;
        REG_ADV_GAIN:  gain_a_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped grid size
  logic [10:0] w_cl, h_cl;
  always_comb begin
    w_cl = gw_r;
    if (gw_r < 11'd8) w_cl = 11'd8;
    if (gw_r > 11'(MAX_WIDTH)) w_cl = 11'(MAX_WIDTH);
    h_cl = gh_r;
    if (gh_r < 11'd8) h_cl = 11'd8;
    if (gh_r > 11'(MAX_HEIGHT)) h_cl = 11'(MAX_HEIGHT);
  end

  logic [2:0]       state_r;
  logic [COL_W-1:0] col_r, c_r;
  logic [ROW_W-1:0] row_r, r_r;
  logic             lcol_r, lrow_r;
  logic [32:0]      cell_r;
  logic [32:0]      win0_r, win1_r;
  logic [32:0]      older_q, newer_q;
  logic [32:0]      older_mem [MAX_WIDTH];
  logic [32:0]      newer_mem [MAX_WIDTH];
  job_t             job_r [2];
  logic [1:0]       job_cnt_r;
  logic             sel_r;

  logic in_acc, last_col, last_row;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign last_col  = {1'b0, col_r} >= (w_cl - 11'd1);
  assign last_row  = {1'b0, row_r} >= (h_cl - 11'd1);

  // row stores: read at accept, write back in the fetch cycle along y
  always_ff @(posedge clk) begin
    if (in_acc) begin
      older_q <= older_mem[col_r];
      newer_q <= newer_mem[col_r];
    end
    if (state_r == ST_FETCH && dir_r) begin
      older_mem[c_r] <= newer_q;
      newer_mem[c_r] <= cell_r;
    end
  end

  // job assembly from the captured cell, window and stores
  job_t j0, j1;
  logic has0, has1;
  always_comb begin
    j0 = '0;
    j1 = '0;
    if (!dir_r) begin
      has0    = (c_r != '0);
      has1    = lcol_r;
      j0.here = win0_r[31:0];
      j0.prev = (c_r >= COL_W'(2)) ? win1_r[31:0] : win0_r[31:0];
      j0.next = cell_r[31:0];
      j0.skip = win0_r[32] || edge_pos({1'b0, c_r - COL_W'(1)}, w_cl);
      j0.row  = r_r;
      j0.col  = c_r - COL_W'(1);
      j0.last = 1'b0;
      j1.here = cell_r[31:0];
      j1.prev = (c_r != '0) ? win0_r[31:0] : cell_r[31:0];
      j1.next = cell_r[31:0];
      j1.skip = cell_r[32] || edge_pos({1'b0, c_r}, w_cl);
      j1.row  = r_r;
      j1.col  = c_r;
      j1.last = lrow_r;
    end else begin
      has0    = (r_r != '0);
      has1    = lrow_r;
      j0.here = newer_q[31:0];
      j0.prev = (r_r >= ROW_W'(2)) ? older_q[31:0] : newer_q[31:0];
      j0.next = cell_r[31:0];
      j0.skip = newer_q[32] || edge_pos({1'b0, r_r - ROW_W'(1)}, h_cl);
      j0.row  = r_r - ROW_W'(1);
      j0.col  = c_r;
      j0.last = 1'b0;
      j1.here = cell_r[31:0];
      j1.prev = (r_r != '0) ? newer_q[31:0] : cell_r[31:0];
      j1.next = cell_r[31:0];
      j1.skip = cell_r[32] || edge_pos({1'b0, r_r}, h_cl);
      j1.row  = r_r;
      j1.col  = c_r;
      j1.last = lcol_r;
    end
  end

  // datapath registers
  job_t              cur;
  logic [31:0]       mh_r;
  logic [32:0]       md_r;
  logic              neg_r, skip_r, last_r;
  logic [ROW_W-1:0]  orow_r;
  logic [COL_W-1:0]  ocol_r;
  logic [47:0]       hsq_r;
  logic [48:0]       hd_r;
  logic [47:0]       ps1_r;
  logic [63:0]       ps0_r, pa0_r;
  logic [48:0]       pa1_r;
  logic signed [32:0] h_s, d_s;
  logic [63:0]       sq_p;
  logic [65:0]       hd_p;
  assign cur  = job_r[sel_r];
  assign h_s  = -$signed({cur.here[31], cur.here});
  assign d_s  = $signed({cur.prev[31], cur.prev}) - $signed({cur.next[31], cur.next});
  assign sq_p = mh_r * mh_r;
  assign hd_p = {1'b0, mh_r} * md_r;

  // final sums and saturation
  logic [62:0]        sh, ra;
  logic signed [64:0] sa, aa, lo_v, up_v, dg_v;
  logic [31:0]        lo_q, dg_q, up_q;
  logic               out_free;
  assign out_free = !out_tvalid || out_tready;
  always_comb begin
    sh   = gain_sat({1'b0, ps1_r}, ps0_r);
    ra   = gain_sat(pa1_r, pa0_r);
    sa   = $signed({2'b0, sh});
    aa   = neg_r ? -$signed({2'b0, ra}) : $signed({2'b0, ra});
    lo_v = aa - sa;
    up_v = -aa - sa;
    dg_v = (sh > {31'b0, INT_MAX}) ? $signed({33'b0, INT_MAX})
                                   : $signed({33'b0, ONE_Q16}) + (sa <<< 1);
    if (skip_r) begin
      lo_q = '0;
      dg_q = ONE_Q16;
      up_q = '0;
    end else begin
      lo_q = sat32(lo_v);
      dg_q = sat32(dg_v);
      up_q = sat32(up_v);
    end
  end

  // control sequence and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      col_r     <= '0;
      row_r     <= '0;
      win0_r    <= '0;
      win1_r    <= '0;
      job_cnt_r <= '0;
      sel_r     <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      // the final stage sets valid itself when it issues
      if (out_tvalid && out_tready && state_r != ST_FIN) out_tvalid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cell_r  <= {in_tuser, in_tdata};
            c_r     <= col_r;
            r_r     <= row_r;
            lcol_r  <= last_col;
            lrow_r  <= last_row;
            if (last_col) begin
              col_r <= '0;
              row_r <= last_row ? '0 : row_r + ROW_W'(1);
            end else begin
              col_r <= col_r + COL_W'(1);
            end
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          win1_r    <= win0_r;
          win0_r    <= cell_r;
          job_r[0]  <= has0 ? j0 : j1;
          job_r[1]  <= j1;
          job_cnt_r <= {1'b0, has0} + {1'b0, has1};
          sel_r     <= 1'b0;
          state_r   <= (has0 || has1) ? ST_OPS : ST_IDLE;
        end
        ST_OPS: begin
          mh_r    <= h_s[32] ? 32'(-h_s) : h_s[31:0];
          md_r    <= d_s[32] ? 33'(-d_s) : 33'(d_s);
          neg_r   <= h_s[32] ^ d_s[32];
          skip_r  <= cur.skip;
          last_r  <= cur.last;
          orow_r  <= cur.row;
          ocol_r  <= cur.col;
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          hsq_r   <= sq_p[63:16];
          hd_r    <= hd_p[64:16];
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          ps1_r   <= hsq_r[47:32] * gain_s_r;
          ps0_r   <= hsq_r[31:0] * gain_s_r;
          pa1_r   <= hd_r[48:32] * gain_a_r;
          pa0_r   <= hd_r[31:0] * gain_a_r;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_tvalid <= 1'b1;
            out_tdata  <= {4'b0, ocol_r, orow_r, up_q, dg_q, lo_q};
            out_tlast  <= last_r;
            if (!sel_r && job_cnt_r == 2'd2) begin
              sel_r   <= 1'b1;
              state_r <= ST_OPS;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_FETCH)
    else $error("accepted cell did not enter fetch");
  a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt_r != 2'd3)
    else $error("more than two results for one cell");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside final stage");
`endif

endmodule
